/* rtl/dependency_worklist_scheduler_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the dependency worklist scheduler
// Define NO_ASSERTIONS to compile every check away.
// ---------------------------------------------------------------------------
`ifndef DEPENDENCY_WORKLIST_SCHEDULER_UNIT_ASSERT_SVH
`define DEPENDENCY_WORKLIST_SCHEDULER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// General implication check on the block clock
`define DWS_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a signal is all zeros whenever a condition holds
`define DWS_ASSERT_ZERO(label, cond, sig, msg) \
    `DWS_ASSERT(label, cond, (sig) == '0, msg)

`else

`define DWS_ASSERT(label, ante, cons, msg)
`define DWS_ASSERT_ZERO(label, cond, sig, msg)

`endif

`endif

/* rtl/dws_pkg.sv */
// ---------------------------------------------------------------------------
// dws_pkg
// Shared constants, types and helpers for the dependency worklist scheduler.
// ---------------------------------------------------------------------------
`default_nettype none

package dws_pkg;

    localparam int NUM_VARS  = 64;
    localparam int NUM_UNITS = 64;

    // table address width
    localparam int VAR_AW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

    localparam logic [6:0] VAR_CNT  = 7'(NUM_VARS);
    localparam logic [6:0] UNIT_CNT = 7'(NUM_UNITS);

    localparam logic [63:0] VAR_MASK  = (NUM_VARS >= 64) ? {64{1'b1}} :
                                        ((64'd1 << NUM_VARS) - 64'd1);
    localparam logic [63:0] UNIT_MASK = (NUM_UNITS >= 64) ? {64{1'b1}} :
                                        ((64'd1 << NUM_UNITS) - 64'd1);

    // command codes on the input channel
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_REPORT = 2'd2;

    // result kinds and finish codes
    localparam logic       KIND_UNIT = 1'b0;
    localparam logic       KIND_DONE = 1'b1;
    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_TERM   = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_START,
        OP_REPORT
    } op_t;

    // one classified word in the queue; data is the row (load) or the
    // changed-variable mask (report), already masked to range
    typedef struct packed {
        op_t         op;
        logic [5:0]  var_idx;
        logic [63:0] data;
        logic        has_branch;
        logic        box_empty;
        logic        term_met;
    } qent_t;

    function automatic logic [63:0] low_mask(input logic [6:0] n);
        logic [63:0] m;
        if (n >= 7'd64) begin
            m = {64{1'b1}};
        end else begin
            m = (64'd1 << n) - 64'd1;
        end
        return m;
    endfunction

    // priority encoder, lowest set bit wins; zero mask gives index 0
    function automatic logic [5:0] lowest_bit(input logic [63:0] m);
        logic [5:0] idx;
        idx = '0;
        for (int i = 63; i >= 0; i--) begin
            if (m[i]) begin
                idx = 6'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

/* rtl/dws_ram.sv */
// ---------------------------------------------------------------------------
// dws_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module dws_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output      logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/dws_front.sv */
// ---------------------------------------------------------------------------
// dws_front
// Accept input words, classify commands, and queue them for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module dws_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output      logic          s_ready,
    input  wire logic [1:0]    s_cmd,
    input  wire logic [5:0]    s_var,
    input  wire logic [63:0]   s_row,
    input  wire logic          s_has_branch,
    input  wire logic [63:0]   s_changed,
    input  wire logic          s_box_empty,
    input  wire logic          s_term_met,
    output      logic          q_valid,
    input  wire logic          q_ready,
    output      dws_pkg::qent_t q_ent
);

    import dws_pkg::*;

    qent_t      q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    qent_t ent;
    logic  keep;
    logic  push;
    logic  pop;

    // classify: drop reserved codes and out-of-range loads here
    always_comb begin
        ent            = '0;
        ent.var_idx    = s_var;
        ent.has_branch = s_has_branch;
        ent.box_empty  = s_box_empty;
        ent.term_met   = s_term_met;
        keep           = 1'b0;
        unique case (s_cmd)
            CMD_LOAD: begin
                ent.op   = OP_LOAD;
                ent.data = s_row & UNIT_MASK;
                keep     = ({1'b0, s_var} < VAR_CNT);
            end
            CMD_START: begin
                ent.op = OP_START;
                keep   = 1'b1;
            end
            CMD_REPORT: begin
                ent.op   = OP_REPORT;
                ent.data = s_changed & VAR_MASK;
                keep     = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_ent   = q_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready && keep;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= ent;
        end
    end

endmodule

`default_nettype wire

/* rtl/dws_back.sv */
// ---------------------------------------------------------------------------
// dws_back
// Execute queued commands: table writes, seeding, row gathering, issue.
// ---------------------------------------------------------------------------
`default_nettype none

module dws_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    output      logic           q_ready,
    input  wire dws_pkg::qent_t q_ent,
    input  wire logic [6:0]     units_in_use,
    output      logic           m_valid,
    input  wire logic           m_ready,
    output      logic           m_kind,
    output      logic [5:0]     m_unit_index,
    output      logic [1:0]     m_finish_status
);

    import dws_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED_RD,
        S_GATHER,
        S_START_RES,
        S_EMPTY_RES,
        S_REPORT_RES
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SEED,
        PH_WORK
    } phase_t;

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [63:0]         pend_reg, pend_next;
    logic [63:0]         seed_reg, seed_next;
    logic [63:0]         scan_reg, scan_next;
    logic [5:0]          cur_reg, cur_next;
    logic                term_reg, term_next;
    logic                br_ok_reg, br_ok_next;
    logic                inflight_reg, inflight_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [NUM_VARS-1:0] vld_reg, vld_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_kind_reg, out_kind_next;
    logic [5:0]          out_unit_reg, out_unit_next;
    logic [1:0]          out_status_reg, out_status_next;

    logic              ram_we;
    logic [VAR_AW-1:0] ram_waddr;
    logic [63:0]       ram_wdata;
    logic              ram_re;
    logic [VAR_AW-1:0] ram_raddr;
    logic [63:0]       ram_rdata;

    logic        out_free;
    logic [6:0]  seed_cnt;
    logic [5:0]  seed_low;
    logic [5:0]  pend_low;
    logic [5:0]  scan_low;
    logic [63:0] above;
    logic [5:0]  work_u;

    dws_ram #(
        .WIDTH (64),
        .DEPTH (NUM_VARS),
        .AW    (VAR_AW)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign seed_cnt = (units_in_use > UNIT_CNT) ? UNIT_CNT : units_in_use;
    assign seed_low = lowest_bit(seed_reg);
    assign pend_low = lowest_bit(pend_reg);
    assign scan_low = lowest_bit(scan_reg);
    assign above    = pend_reg & ~low_mask(7'({1'b0, cur_reg}) + 7'd1);
    assign work_u   = (above != 64'd0) ? lowest_bit(above) : pend_low;

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        pend_next       = pend_reg;
        seed_next       = seed_reg;
        scan_next       = scan_reg;
        cur_next        = cur_reg;
        term_next       = term_reg;
        br_ok_next      = br_ok_reg;
        inflight_next   = inflight_reg;
        vld_next        = vld_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_kind_next   = out_kind_reg;
        out_unit_next   = out_unit_reg;
        out_status_next = out_status_reg;
        q_ready         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = q_ent.var_idx[VAR_AW-1:0];
        ram_wdata       = q_ent.data;
        ram_re          = 1'b0;
        ram_raddr       = q_ent.var_idx[VAR_AW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    unique case (q_ent.op)
                        OP_LOAD: begin
                            ram_we              = 1'b1;
                            vld_next[ram_waddr] = 1'b1;
                        end
                        OP_START: begin
                            pend_next = '0;
                            if (q_ent.has_branch) begin
                                ram_re     = 1'b1;
                                br_ok_next = ({1'b0, q_ent.var_idx} < VAR_CNT);
                                state_next = S_SEED_RD;
                            end else begin
                                seed_next  = low_mask(seed_cnt) & UNIT_MASK;
                                state_next = S_START_RES;
                            end
                        end
                        OP_REPORT: begin
                            if (phase_reg != PH_IDLE) begin
                                if (q_ent.box_empty) begin
                                    state_next = S_EMPTY_RES;
                                end else begin
                                    scan_next     = q_ent.data;
                                    term_next     = q_ent.term_met;
                                    inflight_next = 1'b0;
                                    state_next    = S_GATHER;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SEED_RD: begin
                seed_next  = (br_ok_reg && rd_vld_reg) ? (ram_rdata & UNIT_MASK) : '0;
                state_next = S_START_RES;
            end

            S_GATHER: begin
                if (inflight_reg && rd_vld_reg) begin
                    pend_next = pend_reg | ram_rdata;
                end
                if (scan_reg != 64'd0) begin
                    ram_re        = 1'b1;
                    ram_raddr     = scan_low[VAR_AW-1:0];
                    scan_next     = scan_reg & ~(64'd1 << scan_low);
                    inflight_next = 1'b1;
                end else begin
                    inflight_next = 1'b0;
                    if (!inflight_reg) begin
                        state_next = S_REPORT_RES;
                    end
                end
            end

            S_START_RES: begin
                if (out_free) begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    if (seed_reg == 64'd0) begin
                        phase_next      = PH_IDLE;
                        out_kind_next   = KIND_DONE;
                        out_unit_next   = '0;
                        out_status_next = ST_NONE;
                    end else begin
                        phase_next      = PH_SEED;
                        seed_next       = seed_reg & ~(64'd1 << seed_low);
                        cur_next        = seed_low;
                        out_kind_next   = KIND_UNIT;
                        out_unit_next   = seed_low;
                        out_status_next = ST_NONE;
                    end
                end
            end

            S_EMPTY_RES: begin
                if (out_free) begin
                    state_next      = S_IDLE;
                    phase_next      = PH_IDLE;
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_DONE;
                    out_unit_next   = '0;
                    out_status_next = ST_EMPTY;
                end
            end

            S_REPORT_RES: begin
                if (out_free) begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_DONE;
                    out_unit_next   = '0;
                    out_status_next = ST_NONE;
                    if ((phase_reg == PH_SEED) && (seed_reg != 64'd0)) begin
                        seed_next     = seed_reg & ~(64'd1 << seed_low);
                        cur_next      = seed_low;
                        out_kind_next = KIND_UNIT;
                        out_unit_next = seed_low;
                    end else if (pend_reg == 64'd0) begin
                        phase_next = PH_IDLE;
                    end else if ((phase_reg == PH_SEED) && term_reg) begin
                        phase_next      = PH_IDLE;
                        out_status_next = ST_TERM;
                    end else if (phase_reg == PH_SEED) begin
                        phase_next    = PH_WORK;
                        pend_next     = pend_reg & ~(64'd1 << pend_low);
                        cur_next      = pend_low;
                        out_kind_next = KIND_UNIT;
                        out_unit_next = pend_low;
                    end else begin
                        pend_next     = pend_reg & ~(64'd1 << work_u);
                        cur_next      = work_u;
                        out_kind_next = KIND_UNIT;
                        out_unit_next = work_u;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_vld_next = ram_re ? vld_reg[ram_raddr] : rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_IDLE;
            pend_reg       <= '0;
            seed_reg       <= '0;
            cur_reg        <= '0;
            inflight_reg   <= 1'b0;
            rd_vld_reg     <= 1'b0;
            vld_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            pend_reg       <= pend_next;
            seed_reg       <= seed_next;
            cur_reg        <= cur_next;
            inflight_reg   <= inflight_next;
            rd_vld_reg     <= rd_vld_next;
            vld_reg        <= vld_next;
            out_valid_reg  <= out_valid_next;
        end
        scan_reg       <= scan_next;
        term_reg       <= term_next;
        br_ok_reg      <= br_ok_next;
        out_kind_reg   <= out_kind_next;
        out_unit_reg   <= out_unit_next;
        out_status_reg <= out_status_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_kind          = out_kind_reg;
    assign m_unit_index    = out_unit_reg;
    assign m_finish_status = out_status_reg;

endmodule

`default_nettype wire

/* rtl/dependency_worklist_scheduler_unit.sv */
// Sequence: a load writes the table directly; a start goes to the result register, through a
//   row read first if it branches; a report makes one table read per changed variable.
// Queueing: the back end takes no new word until it has finished the last one; the front
//   queue holds two words so the input side keeps moving while the back end works.
// Reset: synchronous, active low; phase idle, pending and seed masks cleared, units_in_use
//   = 64, and all table rows read as zero at once through per-row valid bits (no clearing pass).
`default_nettype none

`include "dependency_worklist_scheduler_unit_assert.svh"

// ---------------------------------------------------------------------------
// dependency_worklist_scheduler_unit
// Schedules pruning units from a dependency table over seed and work phases.
// ---------------------------------------------------------------------------
module dependency_worklist_scheduler_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration: units_in_use
    input  wire logic         cfg_wr_en,
    input  wire logic [6:0]   cfg_wr_data,
    // input channel
    input  wire logic         s_tvalid,
    output      logic         s_tready,
    // tdata, low bit up: var_index[5:0], row_bits[69:6], has_branch[70],
    // changed_vars[134:71], box_empty[135], term_met[136], zero pad[143:137]
    input  wire logic [143:0] s_tdata,
    // tuser: command[1:0]
    input  wire logic [1:0]   s_tuser,
    // result channel
    output      logic         m_tvalid,
    input  wire logic         m_tready,
    // tdata, low bit up: unit_index[5:0], finish_status[7:6]
    output      logic [7:0]   m_tdata,
    // tuser: kind[0]
    output      logic [0:0]   m_tuser
);

    import dws_pkg::*;

    logic [6:0] units_reg;

    logic       q_valid;
    logic       q_ready;
    qent_t      q_ent;

    logic       res_kind;
    logic [5:0] res_unit;
    logic [1:0] res_status;

    logic       done_word;
    logic       issue_word;

    // Hold the seed count; the host must write it only while the block is idle (not enforced here).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            units_reg <= 7'd64;
        end else if (cfg_wr_en) begin
            units_reg <= cfg_wr_data;
        end
    end

    // Front end: unpack the word, drop reserved commands, queue the rest.
    dws_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .s_cmd        (s_tuser),
        .s_var        (s_tdata[5:0]),
        .s_row        (s_tdata[69:6]),
        .s_has_branch (s_tdata[70]),
        .s_changed    (s_tdata[134:71]),
        .s_box_empty  (s_tdata[135]),
        .s_term_met   (s_tdata[136]),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_ent        (q_ent)
    );

    // Back end: own the table, gather rows, issue units through the output register.
    dws_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_ent           (q_ent),
        .units_in_use    (units_reg),
        .m_valid         (m_tvalid),
        .m_ready         (m_tready),
        .m_kind          (res_kind),
        .m_unit_index    (res_unit),
        .m_finish_status (res_status)
    );

    // Pack the result word.
    assign m_tdata = {res_status, res_unit};
    assign m_tuser = res_kind;

    assign done_word  = m_tvalid && (res_kind == KIND_DONE);
    assign issue_word = m_tvalid && (res_kind == KIND_UNIT);

    // A finished run names no unit.
    `DWS_ASSERT_ZERO(a_done_unit_zero, done_word, res_unit, "finish word carries a unit index")
    // An issue word carries no finish status.
    `DWS_ASSERT_ZERO(a_issue_status_zero, issue_word, res_status, "issue word has a status")
    // Finish status is one of the defined codes.
    `DWS_ASSERT(a_status_legal, m_tvalid, res_status <= ST_TERM, "undefined finish status")

endmodule

`default_nettype wire

/* dv/dws_issue_checker.sv */
// ---------------------------------------------------------------------------
// dws_issue_checker
// Watches the configuration port and both stream channels of the dependency
// worklist scheduler, tracks the scheduler state on its own, and compares
// every result word with the unit issue or finish code that it predicts.
// ---------------------------------------------------------------------------
module dws_issue_checker
    import dws_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [6:0]   cfg_wr_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [7:0]   m_tdata,
    input  logic [0:0]   m_tuser,
    output int           mismatches,
    output int           outstanding,
    output int           taken_words
);

    localparam int PRINT_CAP = 40;

    typedef enum logic [1:0] {
        SCHED_IDLE,
        SCHED_SEED,
        SCHED_WORK
    } sched_state_t;

    typedef struct packed {
        logic       kind;
        logic [5:0] unit;
        logic [1:0] status;
    } issue_t;

    logic [63:0]  dep_rows [64];
    logic [63:0]  pending;
    logic [63:0]  seed_left;
    logic [5:0]   cur_unit;
    logic [6:0]   units_cfg;
    sched_state_t sched_state;
    issue_t       expected_issues [$];

    function automatic int lowest_set(input logic [63:0] m);
        for (int i = 0; i < 64; i++) begin
            if (m[i]) begin
                return i;
            end
        end
        return 0;
    endfunction

    function automatic logic [63:0] below_mask(input int n);
        if (n >= 64) begin
            return '1;
        end
        return (64'd1 << n) - 64'd1;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP) begin
            $display("%0t dws_issue_checker: %s", $time, msg);
        end
        mismatches++;
    endtask

    // take the lowest unit out of a mask and expect it to be issued
    task automatic issue_from(inout logic [63:0] mask);
        int u;
        u = lowest_set(mask);
        mask[u] = 1'b0;
        cur_unit = 6'(u);
        expected_issues.push_back(issue_t'{kind: KIND_UNIT, unit: cur_unit, status: ST_NONE});
    endtask

    task automatic finish_run(input logic [1:0] status);
        sched_state = SCHED_IDLE;
        expected_issues.push_back(issue_t'{kind: KIND_DONE, unit: 6'd0, status: status});
    endtask

    task automatic apply_word(input logic [1:0] cmd, input logic [143:0] w);
        logic [5:0]  var_idx;
        logic [63:0] row_bits;
        logic [63:0] changed;
        logic [63:0] above;
        logic        has_branch;
        logic        box_empty;
        logic        term_met;
        int          n;
        var_idx    = w[5:0];
        row_bits   = w[69:6];
        has_branch = w[70];
        changed    = w[134:71];
        box_empty  = w[135];
        term_met   = w[136];
        case (cmd)
            CMD_LOAD: begin
                dep_rows[var_idx] = row_bits & UNIT_MASK;
            end
            CMD_START: begin
                n = (units_cfg > UNIT_CNT) ? NUM_UNITS : int'(units_cfg);
                seed_left = has_branch ? dep_rows[var_idx] : below_mask(n);
                seed_left &= UNIT_MASK;
                pending = '0;
                if (seed_left == '0) begin
                    finish_run(ST_NONE);
                end else begin
                    sched_state = SCHED_SEED;
                    issue_from(seed_left);
                end
            end
            CMD_REPORT: begin
                if (sched_state != SCHED_IDLE) begin
                    if (box_empty) begin
                        finish_run(ST_EMPTY);
                    end else begin
                        changed &= VAR_MASK;
                        for (int v = 0; v < 64; v++) begin
                            if (changed[v]) begin
                                pending |= dep_rows[v];
                            end
                        end
                        pending &= UNIT_MASK;
                        if (sched_state == SCHED_SEED) begin
                            if (seed_left != '0) begin
                                issue_from(seed_left);
                            end else if (pending == '0) begin
                                finish_run(ST_NONE);
                            end else if (term_met) begin
                                finish_run(ST_TERM);
                            end else begin
                                sched_state = SCHED_WORK;
                                issue_from(pending);
                            end
                        end else if (pending == '0) begin
                            finish_run(ST_NONE);
                        end else begin
                            // round-robin: next pending unit above the last one, else wrap
                            above = pending & ~below_mask(int'(cur_unit) + 1);
                            if (above != '0) begin
                                issue_from(above);
                                pending[cur_unit] = 1'b0;
                            end else begin
                                issue_from(pending);
                            end
                        end
                    end
                end
            end
            default: begin
                // spare command code: drop
            end
        endcase
    endtask

    always @(posedge aclk) begin
        issue_t want;
        if (!aresetn) begin
            for (int v = 0; v < 64; v++) begin
                dep_rows[v] = '0;
            end
            pending     = '0;
            seed_left   = '0;
            cur_unit    = '0;
            units_cfg   = 7'd64;
            sched_state = SCHED_IDLE;
            expected_issues.delete();
            mismatches  = 0;
            taken_words = 0;
        end else begin
            // compare first: a result can never stem from a word taken at the same edge
            if (m_tvalid && m_tready) begin
                if (expected_issues.size() == 0) begin
                    report_mismatch($sformatf("unexpected word kind %0d unit %0d status %0d",
                                              m_tuser[0], m_tdata[5:0], m_tdata[7:6]));
                end else begin
                    want = expected_issues[0];
                    expected_issues.delete(0);
                    if (m_tuser[0] !== want.kind) begin
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  m_tuser[0], want.kind));
                    end
                    if (m_tdata[5:0] !== want.unit) begin
                        report_mismatch($sformatf("unit_index %0d, expected %0d",
                                                  m_tdata[5:0], want.unit));
                    end
                    if (m_tdata[7:6] !== want.status) begin
                        report_mismatch($sformatf("finish_status %0d, expected %0d",
                                                  m_tdata[7:6], want.status));
                    end
                end
            end
            if (cfg_wr_en) begin
                units_cfg = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                taken_words++;
                apply_word(s_tuser, s_tdata);
            end
        end
        outstanding = expected_issues.size();
    end

endmodule

/* dv/tb_dependency_worklist_scheduler_unit.sv */
// ---------------------------------------------------------------------------
// tb_dependency_worklist_scheduler_unit
// Drives load, start and report words into the worklist scheduler under
// random sender gaps and receiver stalls, sweeps units_in_use across its
// range, and lets dws_issue_checker score every issued unit and finish code.
// ---------------------------------------------------------------------------
module tb_dependency_worklist_scheduler_unit;
    import dws_pkg::*;

    // unused command code; the block must drop it
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // idle time before a register write and at the end: long enough for two queued
    // reports to finish, with margin
    localparam int SETTLE_CYCLES = 200;
    // long receiver hold-off that backs the block up into its input
    localparam int HOLD_CYCLES   = 300;
    // cycles with no handshake at all before the run is declared hung
    localparam int STALL_LIMIT   = 3000;
    // input words taken during the random part
    localparam int WORD_GOAL     = 1300;
    localparam int NUM_SEGMENTS  = 8;

    logic         aclk        = 1'b0;
    logic         aresetn     = 1'b0;
    logic         cfg_wr_en   = 1'b0;
    logic [6:0]   cfg_wr_data = '0;
    logic         s_tvalid    = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata     = '0;
    logic [1:0]   s_tuser     = '0;
    logic         m_tvalid;
    logic         m_tready    = 1'b0;
    logic [7:0]   m_tdata;
    logic [0:0]   m_tuser;

    int mismatches;
    int outstanding;
    int taken_words;

    // calm: no idling on either side; steady: sender offers back to back
    bit calm          = 1'b0;
    bit sender_steady = 1'b0;
    bit hold_req      = 1'b0;
    bit holding       = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    dependency_worklist_scheduler_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    dws_issue_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .taken_words (taken_words)
    );

    // Pack one input word, lowest field first; pad bits stay zero.
    function automatic logic [143:0] word_of(input logic [5:0] v, input logic [63:0] row,
                                             input logic hb, input logic [63:0] chg,
                                             input logic be, input logic tm);
        return {7'b0, tm, be, chg, hb, row, v};
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] few_bits(input int k);
        logic [63:0] m;
        m = '0;
        repeat (k) m[6'($urandom_range(0, 63))] = 1'b1;
        return m;
    endfunction

    // Rows are mostly sparse so that runs neither die at once nor never drain.
    function automatic logic [63:0] random_row();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return rand64();
            default: return few_bits($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [63:0] random_changed();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return rand64();
            default: return few_bits($urandom_range(1, 3));
        endcase
    endfunction

    // Offer one word at the current falling edge and hold it until taken.
    // Return at a falling edge; maybe drop tvalid for a burst of idle cycles.
    task automatic offer(input logic [1:0] cmd, input logic [143:0] w);
        int gap;
        s_tuser  <= cmd;
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (!calm && !sender_steady && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Fields that a command does not use carry random junk.
    task automatic send_load(input logic [5:0] v, input logic [63:0] row);
        offer(CMD_LOAD, word_of(v, row, 1'($urandom), rand64(), 1'($urandom), 1'($urandom)));
    endtask

    task automatic send_start(input logic hb, input logic [5:0] v);
        offer(CMD_START, word_of(v, rand64(), hb, rand64(), 1'($urandom), 1'($urandom)));
    endtask

    task automatic send_report(input logic [63:0] chg, input logic be, input logic tm);
        offer(CMD_REPORT, word_of(6'($urandom), rand64(), 1'($urandom), chg, be, tm));
    endtask

    // Write units_in_use only once the block has gone quiet: wait for every
    // expected word, then let any dropped or result-free words drain too.
    task automatic set_units(input logic [6:0] v);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // One propagation run: optional row updates, a start, then a stream of
    // reports with random content, now and then a stray or spare word.
    task automatic one_run();
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) send_load(6'($urandom), random_row());
        end
        send_start($urandom_range(0, 3) != 0, 6'($urandom));
        repeat ($urandom_range(1, 40)) begin
            if ($urandom_range(0, 15) == 0) begin
                offer(2'($urandom_range(0, 3)),
                      word_of(6'($urandom), rand64(), 1'($urandom), rand64(),
                              1'($urandom), 1'($urandom)));
            end
            send_report(random_changed(), $urandom_range(0, 31) == 0,
                        $urandom_range(0, 3) == 0);
        end
    endtask

    // Receiver: bursts of ready and stall, plus one long hold-off on request.
    initial begin
        int n;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                holding  = 1'b1;
                m_tready <= 1'b0;
                n = HOLD_CYCLES;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                holding  = 1'b0;
                m_tready <= 1'b0;
                n = $urandom_range(1, 13);
            end else begin
                holding  = 1'b0;
                m_tready <= 1'b1;
                n = $urandom_range(1, 24);
            end
            repeat (n) @(negedge aclk);
        end
    end

    // Watchdog: end the run if nothing moves on any port for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_dependency_worklist_scheduler_unit: FAIL");
        $finish;
    end

    initial begin
        logic [6:0] seg_units [NUM_SEGMENTS];
        int         goal;
        seg_units = '{7'd127, 7'd1, 7'd64, 7'd0, 7'd65,
                      7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)), 7'd9};

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // --- directed part ---
        // zero units in use: a plain start has nothing to seed
        set_units(7'd0);
        send_load(6'd5, '1);
        send_load(6'd0, 64'h1);
        send_report(64'h1, 1'b0, 1'b0);              // no run open: dropped
        offer(CMD_SPARE, word_of(6'd9, '1, 1'b1, '1, 1'b1, 1'b1));
        send_start(1'b0, 6'd0);                      // empty seed: finish, nothing pending
        send_start(1'b1, 6'd63);                     // branch on a zero row: same

        set_units(7'd2);
        send_load(6'd63, 64'h8000_0000_0000_0001);
        send_start(1'b0, 6'd0);                      // seeds units 0 and 1: issue 0
        send_start(1'b1, 6'd63);                     // restart mid-run from row 63: issue 0
        send_report('0, 1'b0, 1'b0);                 // issue 63, seed set now empty
        send_report(64'h20, 1'b0, 1'b1);             // pending set, host says stop
        send_start(1'b1, 6'd63);
        send_report('0, 1'b0, 1'b0);
        send_report('0, 1'b0, 1'b0);                 // seed done, nothing pending
        send_start(1'b0, 6'd0);
        send_report('1, 1'b0, 1'b0);                 // every variable changed
        send_report('0, 1'b0, 1'b0);                 // enter round-robin at unit 0
        send_report('0, 1'b0, 1'b0);                 // next unit above
        send_report('0, 1'b1, 1'b0);                 // empty box ends the run
        send_report('0, 1'b1, 1'b0);                 // run closed: dropped

        // --- random part, one segment per units_in_use setting ---
        goal = taken_words;
        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            set_units(seg_units[seg]);
            goal += WORD_GOAL / NUM_SEGMENTS;
            if (seg == NUM_SEGMENTS - 1) begin
                calm = 1'b1;
            end
            if (seg == 0) begin
                for (int v = 0; v < 64; v++) begin
                    send_load(6'(v), random_row());
                end
            end
            if (seg == 2) begin
                // back the block up: hold the result side and keep offering
                // reports of a long seed phase so every one yields a word
                hold_req = 1'b1;
                wait (holding);
                sender_steady = 1'b1;
                send_start(1'b0, 6'd0);
                repeat (30) send_report(few_bits(1), 1'b0, 1'b0);
                sender_steady = 1'b0;
            end
            while (taken_words < goal) one_run();
        end
        s_tvalid <= 1'b0;

        // drain: every expected word, then enough quiet cycles to catch extras
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_dependency_worklist_scheduler_unit: PASS");
        end else begin
            $display("tb_dependency_worklist_scheduler_unit: FAIL");
        end
        $finish;
    end

endmodule
